/* design/bitmap_run_allocator_core_macros.svh */
// Assertion helpers shared by the allocator modules.
`ifndef BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMRA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMRA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bmra_pkg.sv */
`default_nettype none

package bmra_pkg;

  localparam int MAP_BITS_DEF = 1024;

  // The map is stored and scanned one word at a time.
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;
  localparam int POS_W  = 6;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_W      = 8;
  localparam int BYTE_SHIFT = 3;

  localparam logic [CFG_W-1:0] BYTES_RESET = 8'd128;

  typedef enum logic [1:0] {
    CMD_TEST  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_CLEAR = 2'd3
  } req_cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_CLR,
    S_RD,
    S_RMW,
    S_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic disp;
    logic rd;
    logic rmw;
    logic scan_run;
    logic clr_step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_scan;
    logic idx_ok;
    logic scan_ok;
    logic clr_last;
    logic scan_done;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

/* design/bmra_ram.sv */
`default_nettype none

module bmra_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/bmra_ctrl.sv */
`default_nettype none
`include "bitmap_run_allocator_core_macros.svh"

module bmra_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output bmra_pkg::ctl_cmd_t        cmd,
  input  wire bmra_pkg::ctl_stat_t  stat
);

  bmra_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmra_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmra_pkg::S_INIT: begin
        if (stat.clr_last) state_nxt = bmra_pkg::S_IDLE;
      end
      bmra_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bmra_pkg::S_DISP;
      end
      bmra_pkg::S_DISP: begin
        if (stat.is_clear) begin
          state_nxt = bmra_pkg::S_CLR;
        end else if (stat.is_scan) begin
          state_nxt = stat.scan_ok ? bmra_pkg::S_SCAN : bmra_pkg::S_OUT;
        end else begin
          state_nxt = stat.idx_ok ? bmra_pkg::S_RD : bmra_pkg::S_OUT;
        end
      end
      bmra_pkg::S_CLR: begin
        if (stat.clr_last) state_nxt = bmra_pkg::S_OUT;
      end
      bmra_pkg::S_RD:   state_nxt = bmra_pkg::S_RMW;
      bmra_pkg::S_RMW:  state_nxt = bmra_pkg::S_OUT;
      bmra_pkg::S_SCAN: begin
        if (stat.scan_done) state_nxt = bmra_pkg::S_OUT;
      end
      bmra_pkg::S_OUT: begin
        if (stat.out_free) state_nxt = bmra_pkg::S_IDLE;
      end
      default: state_nxt = bmra_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      bmra_pkg::S_INIT: cmd.clr_step = 1'b1;
      bmra_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      bmra_pkg::S_DISP: cmd.disp     = 1'b1;
      bmra_pkg::S_CLR:  cmd.clr_step = 1'b1;
      bmra_pkg::S_RD:   cmd.rd       = 1'b1;
      bmra_pkg::S_RMW:  cmd.rmw      = 1'b1;
      bmra_pkg::S_SCAN: cmd.scan_run = 1'b1;
      bmra_pkg::S_OUT:  cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  `BMRA_ASSERT_NEXT(a_accept_disp, clk, rst_n, cmd.accept, state_r == bmra_pkg::S_DISP, "accepted item did not go to dispatch")
  `BMRA_ASSERT_NEXT(a_scan_to_out, clk, rst_n, (state_r == bmra_pkg::S_SCAN) && stat.scan_done, state_r == bmra_pkg::S_OUT, "finished scan did not deliver")
  `BMRA_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, stat.out_free, "result loaded over a waiting result")

endmodule

`default_nettype wire

/* design/bmra_dpath.sv */
`default_nettype none
`include "bitmap_run_allocator_core_macros.svh"

module bmra_dpath #(
  parameter int MAP_BITS = bmra_pkg::MAP_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [bmra_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [bmra_pkg::IDX_W-1:0]     in_bit_index,
  input  wire logic                           in_bit_value,
  input  wire logic [bmra_pkg::LEN_W-1:0]     in_run_length,
  input  wire logic                           cfg_we,
  input  wire logic [bmra_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_bit_state,
  output logic                                out_found,
  output logic      [bmra_pkg::IDX_W-1:0]     out_start_index,
  input  wire bmra_pkg::ctl_cmd_t             cmd,
  output bmra_pkg::ctl_stat_t                 stat
);

  localparam int WW     = bmra_pkg::WORD_W;
  localparam int OW     = bmra_pkg::OFF_W;
  localparam int PW     = bmra_pkg::POS_W;
  localparam int XW     = bmra_pkg::IDX_W;
  localparam int NWORDS = (MAP_BITS + WW - 1) / WW;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int W      = ($clog2(MAP_BITS + 1) + 1 > 12) ? $clog2(MAP_BITS + 1) + 1 : 12;

  logic [bmra_pkg::CFG_W-1:0] bytes_r;
  bmra_pkg::req_cmd_t         req_cmd_r;
  logic [XW-1:0]              req_idx_r;
  logic                       req_val_r;
  logic [bmra_pkg::LEN_W-1:0] req_len_r;

  logic [AW-1:0] clr_ptr_r;
  logic [AW:0]   rd_ptr_r;
  logic [AW-1:0] ev_ptr_r;
  logic          ev_valid_r;
  logic [W-1:0]  carry_r;

  logic          res_state_r, res_found_r;
  logic [XW-1:0] res_start_r;
  logic          out_valid_r, out_bit_state_r, out_found_r;
  logic [XW-1:0] out_start_index_r;

  logic [W-1:0]  bytes8, limit, nwords, idx_ext, base, rem, start, carry_nxt;
  logic [AW-1:0] idx_word;
  logic          rd_more, ev_last, any_hit, clr_last;
  logic [WW-1:0] inuse, word_eff, hit, hit_1h, wr_word;
  logic [OW-1:0] jsel;
  logic [W-1:0]  run [WW];
  logic [PW-1:0] lv [OW+1][WW];

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  always_comb begin
    bytes8   = W'(bytes_r) << bmra_pkg::BYTE_SHIFT;
    limit    = (bytes8 > W'(MAP_BITS)) ? W'(MAP_BITS) : bytes8;
    nwords   = (limit + W'(WW - 1)) >> OW;
    idx_ext  = W'(req_idx_r);
    idx_word = idx_ext[AW+OW-1:OW];
    rd_more  = W'(rd_ptr_r) < nwords;
    ev_last  = W'(ev_ptr_r) == (nwords - W'(1));
    clr_last = clr_ptr_r == AW'(NWORDS - 1);
    base     = W'(ev_ptr_r) << OW;
    rem      = limit - base;
    inuse    = (rem >= W'(WW)) ? '1 : ((WW'(1) << rem[OW-1:0]) - WW'(1));
    // Bits past the end of the map in use act as taken, so no run crosses it.
    word_eff = ram_rdata | ~inuse;
  end

  // Position (plus one) of the nearest taken bit at or below each bit,
  // found by doubling the look-back window at each level.
  always_comb begin
    for (int j = 0; j < WW; j++) begin
      lv[0][j] = word_eff[j] ? PW'(j + 1) : '0;
    end
    for (int s = 0; s < OW; s++) begin
      for (int j = 0; j < WW; j++) begin
        if ((j >= (1 << s)) && (lv[s][j] == '0)) begin
          lv[s+1][j] = lv[s][(j >= (1 << s)) ? (j - (1 << s)) : j];
        end else begin
          lv[s+1][j] = lv[s][j];
        end
      end
    end
  end

  always_comb begin
    jsel = '0;
    for (int j = 0; j < WW; j++) begin
      run[j] = (lv[OW][j] == '0) ? (carry_r + W'(j + 1)) : (W'(j + 1) - W'(lv[OW][j]));
      hit[j] = run[j] >= W'(req_len_r);
    end
    hit_1h = hit & (~hit + WW'(1));
    for (int j = 0; j < WW; j++) begin
      if (hit_1h[j]) jsel = jsel | OW'(j);
    end
    any_hit   = |hit;
    start     = base + W'(jsel) + W'(1) - W'(req_len_r);
    carry_nxt = (lv[OW][WW-1] == '0) ? (carry_r + W'(WW)) : (W'(WW) - W'(lv[OW][WW-1]));
  end

  always_comb begin
    wr_word = ram_rdata;
    wr_word[req_idx_r[OW-1:0]] = req_val_r;
    ram_we    = cmd.clr_step || (cmd.rmw && (req_cmd_r == bmra_pkg::CMD_WRITE));
    ram_waddr = cmd.clr_step ? clr_ptr_r : idx_word;
    ram_wdata = cmd.clr_step ? '0 : wr_word;
    ram_re    = cmd.rd || (cmd.scan_run && rd_more);
    ram_raddr = cmd.rd ? idx_word : rd_ptr_r[AW-1:0];
  end

  bmra_ram #(
    .WIDTH (WW),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.is_clear  = req_cmd_r == bmra_pkg::CMD_CLEAR;
    stat.is_scan   = req_cmd_r == bmra_pkg::CMD_SCAN;
    stat.idx_ok    = idx_ext < limit;
    stat.scan_ok   = (req_len_r != '0) && (limit != '0);
    stat.clr_last  = clr_last;
    stat.scan_done = ev_valid_r && (any_hit || ev_last);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= bmra_pkg::BYTES_RESET;
      clr_ptr_r   <= '0;
      rd_ptr_r    <= '0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) bytes_r <= cfg_wdata;
      if (cmd.clr_step) begin
        clr_ptr_r <= clr_last ? '0 : clr_ptr_r + AW'(1);
      end
      if (cmd.disp) begin
        rd_ptr_r   <= '0;
        ev_valid_r <= 1'b0;
      end else if (cmd.scan_run) begin
        if (rd_more) rd_ptr_r <= rd_ptr_r + (AW+1)'(1);
        ev_valid_r <= rd_more;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_cmd_r <= bmra_pkg::req_cmd_t'(in_cmd);
      req_idx_r <= in_bit_index;
      req_val_r <= in_bit_value;
      req_len_r <= in_run_length;
    end
    if (cmd.scan_run) ev_ptr_r <= rd_ptr_r[AW-1:0];
    if (cmd.disp) begin
      carry_r     <= '0;
      res_state_r <= 1'b0;
      res_found_r <= req_cmd_r == bmra_pkg::CMD_CLEAR;
      res_start_r <= '0;
    end else if (cmd.rmw) begin
      res_state_r <= (req_cmd_r == bmra_pkg::CMD_TEST) ? ram_rdata[req_idx_r[OW-1:0]] : 1'b0;
      res_found_r <= 1'b1;
      res_start_r <= '0;
    end else if (cmd.scan_run && ev_valid_r) begin
      carry_r <= carry_nxt;
      if (stat.scan_done) begin
        res_found_r <= any_hit;
        res_start_r <= any_hit ? start[XW-1:0] : '0;
      end
    end
    if (cmd.out_load) begin
      out_bit_state_r   <= res_state_r;
      out_found_r       <= res_found_r;
      out_start_index_r <= res_start_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_state   = out_bit_state_r;
  assign out_found       = out_found_r;
  assign out_start_index = out_start_index_r;

  `BMRA_ASSERT_IMP(a_wr_excl, clk, rst_n, cmd.clr_step, !cmd.rmw, "clear sweep and bit write collide")
  `BMRA_ASSERT_IMP(a_start_zero, clk, rst_n, out_valid_r && !out_found_r, out_start_index_r == '0, "start index set without a find")
  `BMRA_ASSERT_IMP(a_state_found, clk, rst_n, out_valid_r && out_bit_state_r, out_found_r, "bit state set on a request out of range")

endmodule

`default_nettype wire

/* design/bitmap_run_allocator_core.sv */
// First-fit bit map allocator. Items on the in_ channel carry a request:
// test a bit, write a bit, scan for the lowest run of run_length free bits,
// or clear the whole map. Each item gives exactly one item on the out_
// channel. Both channels use valid/stall; an item moves at a clock edge
// with valid high and stall low. cfg_we writes bytes_in_use, which sets
// how many bytes of the map are in use; write it only while idle.
// One item is worked on at a time. Requests turned away up front (index
// out of range, zero run length, no bits in use) go straight to the
// output; clear sweeps all MAP_BITS/32 map words, and scan reads up to
// ceil(bits_in_use/32) words, one 32-bit map word per cycle through
// the map memory's single read port.
// A new item can be taken in the cycle after the previous result is
// loaded into the output register, even while that result is stalled.
// After reset (synchronous, rst_n low) the map is swept to zero, one word
// per cycle, with in_stall high; bytes_in_use resets to 128. When
// out_stall is high the result holds in the output register and the
// block stalls only once its next result is ready.
`default_nettype none

module bitmap_run_allocator_core #(
  parameter int MAP_BITS = bmra_pkg::MAP_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bmra_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [bmra_pkg::IDX_W-1:0]     in_bit_index,
  input  wire logic                           in_bit_value,
  input  wire logic [bmra_pkg::LEN_W-1:0]     in_run_length,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_bit_state,
  output logic                                out_found,
  output logic      [bmra_pkg::IDX_W-1:0]     out_start_index,
  input  wire logic                           cfg_we,
  input  wire logic [bmra_pkg::CFG_W-1:0]     cfg_wdata
);

  bmra_pkg::ctl_cmd_t  cmd;
  bmra_pkg::ctl_stat_t stat;

  bmra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  bmra_dpath #(
    .MAP_BITS (MAP_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_bit_index    (in_bit_index),
    .in_bit_value    (in_bit_value),
    .in_run_length   (in_run_length),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bit_state   (out_bit_state),
    .out_found       (out_found),
    .out_start_index (out_start_index),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

`default_nettype wire
